[design/hkrb_pkg.sv]
// Shared types, constants and character tables for the keyboard report builder.
`timescale 1ns / 1ps
package hkrb_pkg;

  localparam int SLOT_COUNT = 6;
  localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] ACT_PRESS_CHAR    = 3'd0;
  localparam logic [2:0] ACT_RELEASE_CHAR  = 3'd1;
  localparam logic [2:0] ACT_PRESS_USAGE   = 3'd2;
  localparam logic [2:0] ACT_RELEASE_USAGE = 3'd3;
  localparam logic [2:0] ACT_RELEASE_ALL   = 3'd4;
  localparam logic [2:0] ACT_TYPE_CHAR     = 3'd5;

  localparam logic [7:0] SHIFT_FLAG = 8'h80;
  localparam logic [7:0] ALTGR_FLAG = 8'h40;
  localparam logic [7:0] MOD_SHIFT  = 8'h02;
  localparam logic [7:0] MOD_ALTGR  = 8'h40;
  localparam logic [7:0] MOD_DEAD   = 8'h04;
  localparam logic [7:0] MOD_FIRST  = 8'hE0;
  localparam logic [7:0] MOD_LAST   = 8'hE7;
  localparam logic [7:0] RAW_BASE   = 8'd136;
  localparam logic [7:0] MODKEY_BASE = 8'd128;
  localparam logic [7:0] USAGE_NUS  = 8'h64;
  localparam logic [7:0] CH_GRAVE   = 8'd96;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] U_GRAVE    = 8'h61;
  localparam logic [7:0] U_TILDE_A  = 8'h59;
  localparam logic [7:0] U_TILDE_B  = 8'h5A;
  localparam logic [7:0] U_SPACE_IT = 8'h5E;

  localparam logic [7:0] MAP_US [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
    8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
  };

  localparam logic [7:0] MAP_IT [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'h9f,8'h74,8'ha1,8'ha2,8'ha3,8'h2d,8'ha5,8'ha6,8'hb0,8'h30,8'h36,8'h38,8'h37,8'ha4,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'hb7,8'hb6,8'h64,8'ha7,8'he4,8'had,
    8'h73,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h6f,8'h35,8'h70,8'hae,8'hb8,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'hef,8'hb5,8'hf0,8'hb5,8'h00
  };

  typedef logic [SLOT_COUNT-1:0][7:0] slots_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] mods;
    slots_t     slots;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SPC2,
    ST_SPC3,
    ST_EMIT,
    ST_CLR,
    ST_EMIT2
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic spc2;
    logic spc3;
    logic clear;
    logic emit;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic type_op;
    logic out_free;
  } dp_sts_t;

endpackage

[design/hkrb_if.sv]
// Request channel interfaces: input action channel and report channel.
`timescale 1ns / 1ps
interface hkrb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] code;
  logic       send_now;
  modport source (output valid, action, code, send_now, input ready);
  modport sink (input valid, action, code, send_now, output ready);
endinterface

interface hkrb_out_if;
  logic       valid;
  logic       ready;
  logic       report_sent;
  logic [7:0] modifier_bits;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;
  logic       ok;
  logic       last;
  modport source (output valid, report_sent, modifier_bits, slot_zero, slot_one, slot_two,
                  slot_three, slot_four, slot_five, ok, last, input ready);
  modport sink (input valid, report_sent, modifier_bits, slot_zero, slot_one, slot_two,
                slot_three, slot_four, slot_five, ok, last, output ready);
endinterface

[design/hid_keyboard_report_builder_core.sv]
// Top level of the keyboard report builder: sequencer plus report datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in_if   | in  | valid/ready        | action[2:0], code[7:0], send_now
//  out_if  | out | valid/ready        | report_sent, modifier_bits, slot_zero..five,
//          |     |                    | ok, last
//  cfg     | in  | cfg_we, no ready   | cfg_wdata = key_layout (0 US, 1 IT)
//
// A request steps through accept, execute and emit; IT grave/tilde add two
// extra steps before emit (a second add-usage, used by tilde only, and a
// space add); type char adds a clear and a second emit.
// Reset (rst_n low, synchronous) empties all slots and the modifier byte and
// selects the US layout. A stalled out_if holds the report register; the
// request input stays open while an older report waits to be taken, and the
// sequencer waits in its emit step until the report register frees up.
`timescale 1ns / 1ps
module hid_keyboard_report_builder_core
  import hkrb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  hkrb_in_if.sink    in_if,
  hkrb_out_if.source out_if
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  slots_t  rep_slots;

  // sequencer: owns the input handshake
  hkrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: report state and output register
  hkrb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_if.action),
    .in_code           (in_if.code),
    .in_send_now       (in_if.send_now),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_report_sent   (out_if.report_sent),
    .out_modifier_bits (out_if.modifier_bits),
    .out_slots         (rep_slots),
    .out_ok            (out_if.ok),
    .out_last          (out_if.last)
  );

  // report always has six slots; any beyond the configured count read empty
  logic [5:0][7:0] rep6;
  for (genvar j = 0; j < 6; j++) begin : g_rep
    if (j < SLOT_COUNT) begin : g_used
      assign rep6[j] = rep_slots[j];
    end else begin : g_unused
      assign rep6[j] = 8'h00;
    end
  end

  assign out_if.slot_zero  = rep6[0];
  assign out_if.slot_one   = rep6[1];
  assign out_if.slot_two   = rep6[2];
  assign out_if.slot_three = rep6[3];
  assign out_if.slot_four  = rep6[4];
  assign out_if.slot_five  = rep6[5];

endmodule

[design/hkrb_ctrl.sv]
// Sequencer that steps one request through execute, special-key adds, clear and report emits.
`timescale 1ns / 1ps
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = sts.special ? ST_SPC2 : ST_EMIT;
      ST_SPC2:  state_nxt = ST_SPC3;
      ST_SPC3:  state_nxt = ST_EMIT;
      ST_EMIT:  if (sts.out_free) state_nxt = sts.type_op ? ST_CLR : ST_IDLE;
      ST_CLR:   state_nxt = ST_EMIT2;
      ST_EMIT2: if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC:  cmd.exec  = 1'b1;
      ST_SPC2:  cmd.spc2  = 1'b1;
      ST_SPC3:  cmd.spc3  = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      ST_CLR:   cmd.clear = 1'b1;
      ST_EMIT2: begin
        cmd.emit       = sts.out_free;
        cmd.emit_final = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[design/hkrb_dp.sv]
// Report state, slot update logic and registered report output.
`timescale 1ns / 1ps
module hkrb_dp
  import hkrb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic [2:0]    in_action,
  input  logic [7:0]    in_code,
  input  logic          in_send_now,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_report_sent,
  output logic [7:0]    out_modifier_bits,
  output slots_t        out_slots,
  output logic          out_ok,
  output logic          out_last
);

  // press-usage rule: modifier usages set their mods bit; else first slot holding k or empty takes k
  function automatic upd_t add_usage(input logic [7:0] k, input logic [7:0] mods,
                                     input slots_t slots);
    upd_t u;
    logic hit;
    u.ok    = 1'b0;
    u.mods  = mods;
    u.slots = slots;
    hit     = 1'b0;
    if (k >= MOD_FIRST && k <= MOD_LAST) begin
      u.mods = mods | (8'h01 << k[2:0]);
      u.ok   = 1'b1;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!hit && (slots[i] == k || slots[i] == 8'h00)) begin
          u.slots[i] = k;
          hit        = 1'b1;
        end
      end
      u.ok = hit;
    end
    return u;
  endfunction

  function automatic upd_t press_char(input logic [7:0] code, input logic layout,
                                      input logic [7:0] mods, input slots_t slots);
    upd_t u;
    logic [7:0] k;
    logic [7:0] m;
    logic mapped, present, hit;
    u.ok    = 1'b0;
    u.mods  = mods;
    u.slots = slots;
    m       = mods;
    mapped  = 1'b1;
    present = 1'b0;
    hit     = 1'b0;
    if (code >= RAW_BASE) begin
      k = code - RAW_BASE;
    end else if (code >= MODKEY_BASE) begin
      m = mods | (8'h01 << code[2:0]);
      k = 8'h00;
    end else begin
      k = layout ? MAP_IT[code[6:0]] : MAP_US[code[6:0]];
      if (k == 8'h00) mapped = 1'b0;
      if ((k & SHIFT_FLAG) != 8'h00) begin
        m = m | MOD_SHIFT;
        k = k & 8'h7F;
      end
      if ((k & ALTGR_FLAG) != 8'h00 && k != USAGE_NUS) begin
        m = m | MOD_ALTGR;
        k = k & 8'h3F;
      end
    end
    if (mapped) begin
      u.mods = m;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slots[i] == k) present = 1'b1;
      end
      if (present) begin
        u.ok = 1'b1;
      end else begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!hit && slots[i] == 8'h00) begin
            u.slots[i] = k;
            hit        = 1'b1;
          end
        end
        u.ok = hit;
      end
    end
    return u;
  endfunction

  // release always goes through the US table
  function automatic upd_t release_char(input logic [7:0] code, input logic [7:0] mods,
                                        input slots_t slots);
    upd_t u;
    logic [7:0] k;
    logic [7:0] m;
    logic mapped;
    u.ok    = 1'b0;
    u.mods  = mods;
    u.slots = slots;
    m       = mods;
    mapped  = 1'b1;
    if (code >= RAW_BASE) begin
      k = code - RAW_BASE;
    end else if (code >= MODKEY_BASE) begin
      m = mods & ~(8'h01 << code[2:0]);
      k = 8'h00;
    end else begin
      k = MAP_US[code[6:0]];
      if (k == 8'h00) mapped = 1'b0;
      if ((k & SHIFT_FLAG) != 8'h00) begin
        m = m & ~MOD_SHIFT;
        k = k & 8'h7F;
      end
      if ((k & ALTGR_FLAG) != 8'h00) begin
        m = m & ~MOD_ALTGR;
        k = k & 8'h3F;
      end
    end
    if (mapped) begin
      u.ok   = 1'b1;
      u.mods = m;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (k != 8'h00 && slots[i] == k) u.slots[i] = 8'h00;
      end
    end
    return u;
  endfunction

  // modifier usages clear their mods bit; else zero matching slots, then pack the occupied ones to the front
  function automatic upd_t drop_usage(input logic [7:0] k, input logic [7:0] mods,
                                      input slots_t slots);
    upd_t u;
    slots_t z;
    logic [SLOT_COUNT-1:0][SLOT_CNT_W-1:0] pc;
    logic [SLOT_CNT_W-1:0] cnt;
    u.ok    = 1'b1;
    u.mods  = mods;
    u.slots = slots;
    z       = slots;
    cnt     = '0;
    if (k >= MOD_FIRST && k <= MOD_LAST) begin
      u.mods = mods & ~(8'h01 << k[2:0]);
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slots[i] == k) z[i] = 8'h00;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pc[i] = cnt;
        if (z[i] != 8'h00) cnt = cnt + 1'b1;
      end
      u.slots = '0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (z[i] != 8'h00 && pc[i] == SLOT_CNT_W'(j)) u.slots[j] = z[i];
        end
      end
    end
    return u;
  endfunction

  logic         layout_r;
  logic [7:0]   mods_r, mods_nxt;
  slots_t       slots_r, slots_nxt;
  logic [2:0]   act_r;
  logic [7:0]   code_r;
  logic         send_r;
  logic         ok_r, ok_nxt;
  logic         sent_r, sent_nxt;
  logic         good_r, good_nxt;
  logic         out_valid_r;
  logic         out_sent_r;
  logic [7:0]   out_mods_r;
  slots_t       out_slots_r;
  logic         out_ok_r;
  logic         out_last_r;
  logic         is_press, tilde;
  upd_t         u;
  logic         emit_sent;

  assign is_press     = (act_r == ACT_PRESS_CHAR) || (act_r == ACT_TYPE_CHAR);
  assign tilde        = (code_r == CH_TILDE);
  assign sts.special  = is_press && layout_r && ((code_r == CH_GRAVE) || tilde);
  assign sts.type_op  = (act_r == ACT_TYPE_CHAR);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    mods_nxt  = mods_r;
    slots_nxt = slots_r;
    ok_nxt    = ok_r;
    sent_nxt  = sent_r;
    good_nxt  = good_r;
    u         = '0;
    if (cmd.exec) begin
      case (act_r)
        ACT_PRESS_CHAR, ACT_TYPE_CHAR: begin
          if (sts.special) begin
            u        = add_usage(tilde ? U_TILDE_A : U_GRAVE, mods_r | MOD_DEAD, slots_r);
            good_nxt = u.ok;
          end else begin
            u        = press_char(code_r, layout_r, mods_r, slots_r);
            ok_nxt   = u.ok;
            sent_nxt = u.ok;
          end
        end
        ACT_RELEASE_CHAR: begin
          u        = release_char(code_r, mods_r, slots_r);
          ok_nxt   = u.ok;
          sent_nxt = u.ok;
        end
        ACT_PRESS_USAGE: begin
          u        = add_usage(code_r, mods_r, slots_r);
          ok_nxt   = u.ok;
          sent_nxt = u.ok && send_r;
        end
        ACT_RELEASE_USAGE: begin
          u        = drop_usage(code_r, mods_r, slots_r);
          ok_nxt   = 1'b1;
          sent_nxt = send_r;
        end
        ACT_RELEASE_ALL: begin
          u        = '0;
          u.ok     = 1'b1;
          ok_nxt   = 1'b1;
          sent_nxt = 1'b1;
        end
        default: begin
          u.mods   = mods_r;
          u.slots  = slots_r;
          ok_nxt   = 1'b0;
          sent_nxt = 1'b0;
        end
      endcase
      mods_nxt  = u.mods;
      slots_nxt = u.slots;
    end else if (cmd.spc2) begin
      if (tilde) begin
        u         = add_usage(U_TILDE_B, mods_r, slots_r);
        mods_nxt  = u.mods;
        slots_nxt = u.slots;
        good_nxt  = good_r && u.ok;
      end
    end else if (cmd.spc3) begin
      u         = add_usage(U_SPACE_IT, mods_r, slots_r);
      mods_nxt  = u.mods;
      slots_nxt = u.slots;
      sent_nxt  = u.ok;
      ok_nxt    = good_r && u.ok;
    end else if (cmd.clear) begin
      mods_nxt  = '0;
      slots_nxt = '0;
    end
  end

  assign emit_sent = cmd.emit_final || sent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r    <= 1'b0;
      mods_r      <= '0;
      slots_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) layout_r <= cfg_wdata;
      mods_r  <= mods_nxt;
      slots_r <= slots_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    sent_r <= sent_nxt;
    good_r <= good_nxt;
    if (cmd.load) begin
      act_r  <= in_action;
      code_r <= in_code;
      send_r <= in_send_now;
    end
    if (cmd.emit) begin
      out_sent_r  <= emit_sent;
      out_mods_r  <= emit_sent ? mods_r : 8'h00;
      out_slots_r <= emit_sent ? slots_r : '0;
      out_ok_r    <= ok_r;
      out_last_r  <= cmd.emit_final || !sts.type_op;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_report_sent   = out_sent_r;
  assign out_modifier_bits = out_mods_r;
  assign out_slots         = out_slots_r;
  assign out_ok            = out_ok_r;
  assign out_last          = out_last_r;

endmodule

[design/hkrb_checker.sv]
// Port-level checks for the keyboard report builder, bound to the top level.
`timescale 1ns / 1ps
module hkrb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_report_sent,
  input logic [7:0] out_modifier_bits,
  input logic [7:0] out_slot_zero,
  input logic [7:0] out_slot_five,
  input logic       out_last
);

  // one request in flight: nothing accepted the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // a report that is not sent carries empty fields
  a_empty_when_unsent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_report_sent |->
      out_modifier_bits == 8'h00 && out_slot_zero == 8'h00 && out_slot_five == 8'h00)
    else $error("unsent result carries report data");

  // while the first half of a type request is on the output, input stays closed
  a_type_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input opened before final result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_report_sent   (out_if.report_sent),
  .out_modifier_bits (out_if.modifier_bits),
  .out_slot_zero     (out_if.slot_zero),
  .out_slot_five     (out_if.slot_five),
  .out_last          (out_if.last)
);

[sim/hid_keyboard_report_builder_core_test.sv]
// Testbench for the keyboard report builder: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module hid_keyboard_report_builder_core_test
  import hkrb_pkg::*;
();

  // one report as seen on the output channel
  typedef struct packed {
    logic       sent;
    logic [7:0] mods;
    logic [7:0] s0, s1, s2, s3, s4, s5;
    logic       ok;
    logic       last;
  } report_t;

  // Keyboard state mirror plus the queue of expected reports.
  class report_scoreboard;
    logic       layout_it;
    logic [7:0] mods;
    logic [7:0] slots [SLOT_COUNT];
    report_t    pending [$];
    int         mismatches;

    function void clear_keys();
      mods = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void make_report(logic sent, logic ok, logic last);
      report_t r;
      r = '0;
      r.sent = sent;
      if (sent) begin
        r.mods = mods;
        r.s0 = slots[0]; r.s1 = slots[1]; r.s2 = slots[2];
        r.s3 = slots[3]; r.s4 = slots[4]; r.s5 = slots[5];
      end
      r.ok = ok;
      r.last = last;
      pending.push_back(r);
    endfunction

    function logic is_modkey(logic [7:0] u);
      return u >= MOD_FIRST && u <= MOD_LAST;
    endfunction

    function logic add_key(logic [7:0] u);
      if (is_modkey(u)) begin
        mods[u - MOD_FIRST] = 1'b1;
        return 1'b1;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slots[i] == u) return 1'b1;
        if (slots[i] == 0) begin
          slots[i] = u;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void drop_key(logic [7:0] u);
      int n;
      if (is_modkey(u)) begin
        mods[u - MOD_FIRST] = 1'b0;
        return;
      end
      n = 0;
      foreach (slots[i]) if (slots[i] == u) slots[i] = '0;
      foreach (slots[i]) if (slots[i] != 0) begin
        slots[n] = slots[i];
        n++;
      end
      for (int i = n; i < SLOT_COUNT; i++) slots[i] = '0;
    endfunction

    // press a character; returns ok, sets sent
    function logic press_char(logic [7:0] code, output logic sent);
      logic [7:0] k;
      logic       hit, good, fin;
      sent = 1'b0;
      hit = 1'b0;
      if (code >= RAW_BASE) k = code - RAW_BASE;
      else if (code >= MODKEY_BASE) begin
        mods[code - MODKEY_BASE] = 1'b1;
        k = '0;
      end else begin
        if (layout_it && (code == CH_GRAVE || code == CH_TILDE)) begin
          // dead-key sequence: every add runs, report only if the last lands
          good = 1'b1;
          mods |= MOD_DEAD;
          if (code == CH_GRAVE) good = add_key(U_GRAVE);
          else begin
            good = add_key(U_TILDE_A);
            good = add_key(U_TILDE_B) && good;
          end
          fin = add_key(U_SPACE_IT);
          sent = fin;
          return good && fin;
        end
        k = layout_it ? MAP_IT[code[6:0]] : MAP_US[code[6:0]];
        if (k == 0) return 1'b0;
        if (k & SHIFT_FLAG) begin
          mods |= MOD_SHIFT;
          k &= 8'h7f;
        end
        if ((k & ALTGR_FLAG) && k != USAGE_NUS) begin
          mods |= MOD_ALTGR;
          k &= 8'h3f;
        end
      end
      foreach (slots[i]) if (slots[i] == k) hit = 1'b1;
      if (!hit) begin
        int i;
        for (i = 0; i < SLOT_COUNT; i++) if (slots[i] == 0) break;
        if (i == SLOT_COUNT) return 1'b0;
        slots[i] = k;
      end
      sent = 1'b1;
      return 1'b1;
    endfunction

    // release always goes through the US table
    function logic release_char(logic [7:0] code);
      logic [7:0] k;
      if (code >= RAW_BASE) k = code - RAW_BASE;
      else if (code >= MODKEY_BASE) begin
        mods[code - MODKEY_BASE] = 1'b0;
        k = '0;
      end else begin
        k = MAP_US[code[6:0]];
        if (k == 0) return 1'b0;
        if (k & SHIFT_FLAG) begin
          mods &= ~MOD_SHIFT;
          k &= 8'h7f;
        end
        if (k & ALTGR_FLAG) begin
          mods &= ~MOD_ALTGR;
          k &= 8'h3f;
        end
      end
      foreach (slots[i]) if (k != 0 && slots[i] == k) slots[i] = '0;
      return 1'b1;
    endfunction

    function void note_request(logic [2:0] act, logic [7:0] code, logic send);
      logic ok, sent;
      case (act)
        ACT_PRESS_CHAR: begin
          ok = press_char(code, sent);
          make_report(sent, ok, 1'b1);
        end
        ACT_RELEASE_CHAR: begin
          ok = release_char(code);
          make_report(ok, ok, 1'b1);
        end
        ACT_PRESS_USAGE: begin
          ok = add_key(code);
          make_report(ok && send, ok, 1'b1);
        end
        ACT_RELEASE_USAGE: begin
          drop_key(code);
          make_report(send, 1'b1, 1'b1);
        end
        ACT_RELEASE_ALL: begin
          clear_keys();
          make_report(1'b1, 1'b1, 1'b1);
        end
        ACT_TYPE_CHAR: begin
          ok = press_char(code, sent);
          make_report(sent, ok, 1'b0);
          clear_keys();
          make_report(1'b1, ok, 1'b1);
        end
        default: make_report(1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("report mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  hkrb_in_if  in_if ();
  hkrb_out_if out_if ();

  hid_keyboard_report_builder_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #1 clk = ~clk;

  report_scoreboard board = new();
  int send_idle_pct = 0;     // sender idle chance, percent
  int recv_idle_pct = 0;     // receiver stall chance, percent
  int hold_off = 0;          // long receiver stall, cycles left

  initial begin
    in_if.valid = 1'b0;
    in_if.action = '0;
    in_if.code = '0;
    in_if.send_now = 1'b0;
    out_if.ready = 1'b0;
  end

  // receiver: checks each taken report, random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_report({out_if.report_sent, out_if.modifier_bits, out_if.slot_zero,
                          out_if.slot_one, out_if.slot_two, out_if.slot_three,
                          out_if.slot_four, out_if.slot_five, out_if.ok, out_if.last});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // one request; random idle gap first, then hold valid until taken.
  // valid stays up after the accept so back-to-back requests need no gap.
  task automatic send_request(logic [2:0] act, logic [7:0] code, logic send);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.code <= code;
    in_if.send_now <= send;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_request(act, code, send);
  endtask

  // wait for the block to drain, then let the sequencer settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_layout(logic it);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= it;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.layout_it = it;
  endtask

  // typing-heavy random request mix
  task automatic random_request();
    logic [2:0] act;
    logic [7:0] code;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) act = ACT_PRESS_CHAR;
    else if (pick < 45) act = ACT_RELEASE_CHAR;
    else if (pick < 60) act = ACT_PRESS_USAGE;
    else if (pick < 72) act = ACT_RELEASE_USAGE;
    else if (pick < 78) act = ACT_RELEASE_ALL;
    else if (pick < 95) act = ACT_TYPE_CHAR;
    else act = 3'($urandom_range(7));
    pick = $urandom_range(9);
    if (act == ACT_PRESS_USAGE || act == ACT_RELEASE_USAGE)
      code = (pick < 2) ? 8'($urandom_range(MOD_FIRST, MOD_LAST))
           : (pick < 7) ? 8'($urandom_range(4, 12)) : 8'($urandom);
    else
      code = (pick < 6) ? 8'($urandom_range(32, 127))
           : (pick < 7) ? (($urandom_range(1) != 0) ? CH_GRAVE : CH_TILDE) : 8'($urandom);
    send_request(act, code, 1'($urandom));
  endtask

  initial begin
    board.layout_it = 1'b0;
    board.clear_keys();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every action, extreme codes, full slots, dead keys
    send_request(ACT_PRESS_CHAR, 8'h00, 1'b0);        // unmapped
    send_request(ACT_PRESS_CHAR, 8'h41, 1'b0);        // shifted letter
    send_request(ACT_PRESS_CHAR, 8'h81, 1'b0);        // modifier key code
    send_request(ACT_PRESS_CHAR, 8'h88, 1'b0);        // usage 0 via raw base
    send_request(ACT_PRESS_CHAR, 8'hFF, 1'b1);        // top raw usage
    send_request(ACT_RELEASE_CHAR, 8'h41, 1'b1);
    send_request(ACT_RELEASE_CHAR, 8'h7F, 1'b0);      // unmapped release
    for (int i = 0; i < 7; i++) send_request(ACT_PRESS_USAGE, 8'(4 + i), 1'b1);
    send_request(ACT_PRESS_CHAR, 8'h88, 1'b1);        // slots full, usage 0
    send_request(ACT_PRESS_USAGE, MOD_LAST, 1'b1);
    send_request(ACT_RELEASE_USAGE, 8'd5, 1'b1);      // compaction
    send_request(ACT_RELEASE_USAGE, MOD_LAST, 1'b0);
    send_request(ACT_RELEASE_ALL, 8'h00, 1'b0);
    send_request(3'd6, 8'hAA, 1'b1);
    send_request(3'd7, 8'h55, 1'b0);
    set_layout(1'b1);
    send_request(ACT_TYPE_CHAR, CH_GRAVE, 1'b0);
    send_request(ACT_PRESS_CHAR, CH_TILDE, 1'b0);
    send_request(ACT_PRESS_CHAR, 8'h3C, 1'b0);        // IT usage 0x64, no AltGr added
    send_request(ACT_TYPE_CHAR, 8'h7B, 1'b1);         // AltGr entry

    // random phases: receiver-heavy idle, sender-heavy idle, no idle; layout picked at random
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < 350; n++) begin
        if (n % 100 == 50) set_layout(1'($urandom));
        if (phase == 2 && n == 10) hold_off = 300;  // back-pressure fills the block
        random_request();
      end
    end
    set_layout(1'b0);
    repeat (20) random_request();
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
design/hkrb_pkg.sv
design/hkrb_if.sv
design/hkrb_ctrl.sv
design/hkrb_dp.sv
design/hid_keyboard_report_builder_core.sv
design/hkrb_checker.sv
sim/hid_keyboard_report_builder_core_test.sv
